FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define FCPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define FCPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fcpq_pkg.sv
// ----------------------------------------------------------------------------
// fcpq_pkg
// shared types and constants of the four-class priority queue
// ----------------------------------------------------------------------------
package fcpq_pkg;

    localparam int NUM_CLASSES       = 4;
    localparam int CLS_W             = 2;
    localparam int ID_W              = 16;
    localparam int DEF_CLASS_DEPTH   = 16;

    // request mode
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // classes in service order: A, D, C, B
    typedef enum logic [CLS_W-1:0] {
        CLS_A = 2'd0,
        CLS_D = 2'd1,
        CLS_C = 2'd2,
        CLS_B = 2'd3
    } class_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    enq;
        logic    deq;
        logic    ld_status;
        status_t status;
        logic    ld_deq;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cls_full;
        logic any_avail;
    } dp_sts_t;

endpackage

FILE: rtl/fcpq_req_if.sv
// ----------------------------------------------------------------------------
// fcpq_req_if
// request channel: enqueue or dequeue beats
// ----------------------------------------------------------------------------
interface fcpq_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [1:0]  prio_class;
    logic [15:0] entry_id;

    modport source (output valid, mode, prio_class, entry_id, input ready);
    modport sink   (input valid, mode, prio_class, entry_id, output ready);
endinterface

FILE: rtl/fcpq_rsp_if.sv
// ----------------------------------------------------------------------------
// fcpq_rsp_if
// response channel: one result beat per request
// ----------------------------------------------------------------------------
interface fcpq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [1:0]  out_class;

    modport source (output valid, status, out_id, out_class, input ready);
    modport sink   (input valid, status, out_id, out_class, output ready);
endinterface

FILE: rtl/fcpq_ram.sv
// ----------------------------------------------------------------------------
// fcpq_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module fcpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/fcpq_ctrl.sv
// ----------------------------------------------------------------------------
// fcpq_ctrl
// handshake control and sequencing of enqueue and dequeue beats
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_mode,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  fcpq_pkg::dp_sts_t  sts,
    output fcpq_pkg::ctrl_cmd_t cmd
);
    import fcpq_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd            = '0;
        cmd.status     = ST_ENQ;
        req_ready      = 1'b0;
        accept         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = !out_valid_reg || rsp_ready;
                accept    = req_valid && req_ready;
                if (accept)
                begin
                    if (req_mode == MODE_ENQ)
                    begin
                        cmd.ld_status  = 1'b1;
                        out_valid_next = 1'b1;
                        if (sts.cls_full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.enq    = 1'b1;
                            cmd.status = ST_ENQ;
                        end
                    end
                    else if (sts.any_avail)
                    begin
                        // ram read issued now, data latched next cycle
                        cmd.deq    = 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        cmd.ld_status  = 1'b1;
                        cmd.status     = ST_EMPTY;
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                cmd.ld_deq     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;

    `FCPQ_ASSERT_IMPL(a_read_slot_free, state_reg == S_READ, !out_valid_reg, "output busy on ram read")
    `FCPQ_ASSERT_NEXT(a_accept_leads_result, accept, out_valid_reg || state_reg == S_READ, "accepted beat produced no result")

endmodule

FILE: rtl/fcpq_dp.sv
// ----------------------------------------------------------------------------
// fcpq_dp
// per-class ring pointers, occupancy counts, entry ram and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcpq_dp #(
    parameter int CLASS_DEPTH = fcpq_pkg::DEF_CLASS_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [fcpq_pkg::CLS_W-1:0]   req_class,
    input  logic [fcpq_pkg::ID_W-1:0]    req_id,
    input  fcpq_pkg::ctrl_cmd_t          cmd,
    output fcpq_pkg::dp_sts_t            sts,
    output logic [1:0]                   status,
    output logic [fcpq_pkg::ID_W-1:0]    out_id,
    output logic [fcpq_pkg::CLS_W-1:0]   out_class
);
    import fcpq_pkg::*;

    localparam int RAM_DEPTH = NUM_CLASSES * CLASS_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int PTR_W     = $clog2(CLASS_DEPTH);
    localparam int CNT_W     = $clog2(CLASS_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(CLASS_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(CLASS_DEPTH);
    localparam logic [ADDR_W-1:0] BASE_STEP = ADDR_W'(CLASS_DEPTH);

    logic [PTR_W-1:0] rd_ptr_reg [NUM_CLASSES];
    logic [PTR_W-1:0] rd_ptr_next[NUM_CLASSES];
    logic [PTR_W-1:0] wr_ptr_reg [NUM_CLASSES];
    logic [PTR_W-1:0] wr_ptr_next[NUM_CLASSES];
    logic [CNT_W-1:0] cnt_reg    [NUM_CLASSES];
    logic [CNT_W-1:0] cnt_next   [NUM_CLASSES];

    class_t           pick;
    logic             any_avail;
    logic             cnt_ok;
    class_t           deq_cls_reg, deq_cls_next;
    logic [1:0]       status_reg, status_next;
    logic [ID_W-1:0]  out_id_reg, out_id_next;
    logic [CLS_W-1:0] out_class_reg, out_class_next;

    logic [ADDR_W-1:0] waddr, raddr;
    logic [ID_W-1:0]   rdata;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    // highest-ranked non-empty class
    always_comb
    begin
        pick      = CLS_A;
        any_avail = 1'b0;
        cnt_ok    = 1'b1;
        for (int k = NUM_CLASSES - 1; k >= 0; k--)
        begin
            if (cnt_reg[k] != '0)
            begin
                pick      = class_t'(k);
                any_avail = 1'b1;
            end
            if (cnt_reg[k] > FULL_CNT)
            begin
                cnt_ok = 1'b0;
            end
        end
    end

    assign sts.cls_full  = (cnt_reg[req_class] == FULL_CNT);
    assign sts.any_avail = any_avail;

    assign waddr = ADDR_W'(req_class) * BASE_STEP + ADDR_W'(wr_ptr_reg[req_class]);
    assign raddr = ADDR_W'(pick) * BASE_STEP + ADDR_W'(rd_ptr_reg[pick]);

    fcpq_ram #(
        .WIDTH (ID_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.enq),
        .waddr (waddr),
        .wdata (req_id),
        .re    (cmd.deq),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        cnt_next       = cnt_reg;
        deq_cls_next   = deq_cls_reg;
        status_next    = status_reg;
        out_id_next    = out_id_reg;
        out_class_next = out_class_reg;
        if (cmd.enq)
        begin
            wr_ptr_next[req_class] = ptr_inc(wr_ptr_reg[req_class]);
            cnt_next[req_class]    = cnt_reg[req_class] + 1'b1;
        end
        if (cmd.deq)
        begin
            rd_ptr_next[pick] = ptr_inc(rd_ptr_reg[pick]);
            cnt_next[pick]    = cnt_reg[pick] - 1'b1;
            deq_cls_next      = pick;
        end
        if (cmd.ld_status)
        begin
            status_next    = cmd.status;
            out_id_next    = '0;
            out_class_next = '0;
        end
        if (cmd.ld_deq)
        begin
            status_next    = ST_DEQ;
            out_id_next    = rdata;
            out_class_next = deq_cls_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                rd_ptr_reg[k] <= '0;
                wr_ptr_reg[k] <= '0;
                cnt_reg[k]    <= '0;
            end
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deq_cls_reg   <= deq_cls_next;
        status_reg    <= status_next;
        out_id_reg    <= out_id_next;
        out_class_reg <= out_class_next;
    end

    assign status    = status_reg;
    assign out_id    = out_id_reg;
    assign out_class = out_class_reg;

    `FCPQ_ASSERT(a_cnt_bound, cnt_ok, "class occupancy above depth")
    `FCPQ_ASSERT_IMPL(a_ld_after_read, cmd.ld_deq, $past(cmd.deq), "ram data latched without read")

endmodule

FILE: rtl/four_class_priority_queue.sv
// ----------------------------------------------------------------------------
// four_class_priority_queue
// strict priority queue with four classes served A, D, C, B, fifo per class
// ----------------------------------------------------------------------------
//  channel | dir | beat content
//  --------+-----+--------------------------------------------------
//  req     | in  | mode, prio_class, entry_id (enqueue or dequeue)
//  rsp     | out | status, out_id, out_class (one per request beat)
//
//  enqueue, class full and queue empty: result loaded straight into the result register
//  dequeue: extra S_READ state, set by the registered read port of the entry ram
//  rst_n clears pointers, counts and handshake state; ram content is not cleared
//  the result register lets a new request be taken in the cycle its
//  predecessor's result is taken; a stalled rsp holds req off after that
// ----------------------------------------------------------------------------
module four_class_priority_queue #(
    parameter int CLASS_DEPTH = fcpq_pkg::DEF_CLASS_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    fcpq_req_if.sink   req,
    fcpq_rsp_if.source rsp
);
    import fcpq_pkg::*;

    // command and status between controller and datapath
    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // controller: handshakes and the dequeue read sequence
    fcpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_mode  (req.mode),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: ring pointers, counts, priority pick, entry ram, result
    fcpq_dp #(
        .CLASS_DEPTH (CLASS_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_class (req.prio_class),
        .req_id    (req.entry_id),
        .cmd       (cmd),
        .sts       (sts),
        .status    (rsp.status),
        .out_id    (rsp.out_id),
        .out_class (rsp.out_class)
    );

endmodule
